[src/vertex_rotate_and_project_top_defines.svh]
// Assertion macros shared by the vertex rotate and project block.
// Holds no logic; files that assert include it by its bare name.
`ifndef VERTEX_ROTATE_AND_PROJECT_TOP_DEFINES_SVH
`define VERTEX_ROTATE_AND_PROJECT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VRP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VRP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define VRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[src/vrp_pkg.sv]
// Package for the vertex rotate and project block: widths, codes and reset values.
// No dependencies.
package vrp_pkg;
   localparam int NUM_VERTICES_DEF = 4;
   localparam int FRAC_BITS_DEF    = 8;
   localparam int COORD_W          = 24;
   localparam int SUM_W            = 25;
   localparam int MUL_B_W          = 32;
   localparam int PROD_W           = 57;
   localparam int ACC_W            = 59;
   localparam int DEN_W            = 34;
   localparam int CNT_W            = 6;

   localparam logic [2:0] CMD_LOAD  = 3'd0;
   localparam logic [2:0] CMD_TRANS = 3'd1;
   localparam logic [2:0] CMD_ROT_YP = 3'd2;
   localparam logic [2:0] CMD_ROT_YN = 3'd3;
   localparam logic [2:0] CMD_ROT_XP = 3'd4;
   localparam logic [2:0] CMD_ROT_XN = 3'd5;

   localparam logic [2:0] REG_FOCAL = 3'd0;
   localparam logic [2:0] REG_CX    = 3'd1;
   localparam logic [2:0] REG_CY    = 3'd2;
   localparam logic [2:0] REG_COS   = 3'd3;
   localparam logic [2:0] REG_SIN   = 3'd4;

   localparam logic [14:0] FOCAL_RST = 15'd1000;
   localparam logic [11:0] CX_RST    = 12'd320;
   localparam logic [11:0] CY_RST    = 12'd240;
   localparam logic [30:0] COS_RST   = 31'd1073741415;
   localparam logic [30:0] SIN_RST   = 31'd937017;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Clamp a wide signed value to the coordinate range.
   function automatic coord_type sat_coord(input logic signed [63:0] v);
      coord_type r;
      if (v > 64'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction
endpackage

[src/vertex_rotate_and_project_top.sv]
// Top level of the vertex rotate and project block: vertex memory, sequencer,
// shared multiplier and restoring divider. Depends on vrp_pkg and the defines header.
// Each vertex runs through two 57-step divisions, one quotient bit a cycle; a rotation
// first runs its product steps and a write-back, and a vertex behind the camera skips the
// divisions. busy falls in the cycle of the last result beat, and a new command is taken
// only while busy is low; results cannot be stalled. Reset is synchronous and clears the
// vertices (through valid bits), the offset and the registers.
`include "vertex_rotate_and_project_top_defines.svh"
module vertex_rotate_and_project_top #(
   parameter int NUM_VERTICES = vrp_pkg::NUM_VERTICES_DEF,
   parameter int FRAC_BITS    = vrp_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [1:0]         req_vertex_index,
   input  logic signed [23:0] req_in_x,
   input  logic signed [23:0] req_in_y,
   input  logic signed [23:0] req_in_z,
   output logic               rsp_valid,
   output logic [1:0]         rsp_out_index,
   output logic signed [23:0] rsp_screen_x,
   output logic signed [23:0] rsp_screen_y,
   output logic               rsp_behind,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int FW = 15 + FRAC_BITS;
   localparam int CW = vrp_pkg::COORD_W;
   localparam int MW = vrp_pkg::PROD_W;
   localparam int DW = vrp_pkg::DEN_W;
   localparam int AC = vrp_pkg::ACC_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_LATCH = 4'd2;
   localparam logic [3:0] S_ROT   = 4'd3;
   localparam logic [3:0] S_WB    = 4'd4;
   localparam logic [3:0] S_PROJ  = 4'd5;
   localparam logic [3:0] S_CHK   = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_DSET  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_FIN   = 4'd10;

   // Configuration registers.
   logic [14:0] focal_ff;
   logic [11:0] cx_ff, cy_ff;
   logic [30:0] cos_ff, sin_ff;
   logic        cfg_wr;

   // Vertex memory with one valid bit per entry.
   logic [3*CW-1:0]        mem [NUM_VERTICES];
   logic [NUM_VERTICES-1:0] vld_ff, vld_in;
   logic [3*CW-1:0]        rd_data_ff;
   logic                   rd_vld_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr, rd_addr;
   logic [3*CW-1:0]        mem_wdata;

   // Sequencer state.
   logic [3:0]    state_ff, state_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [AW-1:0] vi_ff, vi_in;
   logic [2:0]    step_ff, step_in;
   vrp_pkg::coord_type vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   vrp_pkg::coord_type offx_ff, offx_in, offy_ff, offy_in, offz_ff, offz_in;
   logic signed [AC-1:0] acca_ff, acca_in, accb_ff, accb_in;
   logic signed [MW-1:0] prod_ff, prod_in;
   logic signed [CW:0]   xs_ff, xs_in, ys_ff, ys_in;
   logic signed [DW-1:0] den_ff, den_in;
   logic                 pass_ff, pass_in;
   logic [MW-1:0]        num_ff, num_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [vrp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   vrp_pkg::coord_type   sx_ff, sx_in;
   logic                 ov_ff, ov_in, ol_ff, ol_in, ob_ff, ob_in;
   logic [1:0]           oi_ff, oi_in;
   vrp_pkg::coord_type   osx_ff, osx_in, osy_ff, osy_in;

   // Shared multiplier operands.
   logic signed [CW:0]               mul_a;
   logic signed [vrp_pkg::MUL_B_W-1:0] mul_b;

   logic                  accept;
   logic                  about_y, k1_pos, is_rot;
   logic signed [31:0]    c_s, s_s, k1_s, k2_s, f_s;
   logic signed [CW:0]    a_v, z_v;
   logic [31:0]           idx_w, vi_w;
   logic signed [AC-1:0]  rnd_a, rnd_b;
   logic [DW-1:0]         rem_sh, diff;
   logic signed [MW:0]    q_s;
   logic signed [63:0]    cx_w, cy_w, scr;
   logic                  vlast;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   // Register write and read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= vrp_pkg::FOCAL_RST;
         cx_ff    <= vrp_pkg::CX_RST;
         cy_ff    <= vrp_pkg::CY_RST;
         cos_ff   <= vrp_pkg::COS_RST;
         sin_ff   <= vrp_pkg::SIN_RST;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            vrp_pkg::REG_FOCAL: focal_ff <= pwdata[14:0];
            vrp_pkg::REG_CX:    cx_ff    <= pwdata[11:0];
            vrp_pkg::REG_CY:    cy_ff    <= pwdata[11:0];
            vrp_pkg::REG_COS:   cos_ff   <= pwdata[30:0];
            vrp_pkg::REG_SIN:   sin_ff   <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         vrp_pkg::REG_FOCAL: prdata = {17'd0, focal_ff};
         vrp_pkg::REG_CX:    prdata = {20'd0, cx_ff};
         vrp_pkg::REG_CY:    prdata = {20'd0, cy_ff};
         vrp_pkg::REG_COS:   prdata = {1'b0, cos_ff};
         vrp_pkg::REG_SIN:   prdata = {1'b0, sin_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // Derived operands.
   assign about_y = (cmd_ff == vrp_pkg::CMD_ROT_YP) || (cmd_ff == vrp_pkg::CMD_ROT_YN);
   assign k1_pos  = (cmd_ff == vrp_pkg::CMD_ROT_YP) || (cmd_ff == vrp_pkg::CMD_ROT_XN);
   assign is_rot  = (cmd_ff == vrp_pkg::CMD_ROT_YP) || (cmd_ff == vrp_pkg::CMD_ROT_YN) ||
                    (cmd_ff == vrp_pkg::CMD_ROT_XP) || (cmd_ff == vrp_pkg::CMD_ROT_XN);
   assign c_s  = {1'b0, cos_ff};
   assign s_s  = {1'b0, sin_ff};
   assign k1_s = k1_pos ? s_s : -s_s;
   assign k2_s = -k1_s;
   assign f_s  = {{(32-FW){1'b0}}, focal_ff, {FRAC_BITS{1'b0}}};
   assign a_v  = about_y ? {vx_ff[CW-1], vx_ff} : {vy_ff[CW-1], vy_ff};
   assign z_v  = {vz_ff[CW-1], vz_ff};
   assign idx_w = {30'd0, req_vertex_index};
   assign vi_w  = 32'(vi_ff);
   assign vlast = (vi_ff == AW'(NUM_VERTICES-1));
   assign cx_w  = {{(52-FRAC_BITS){1'b0}}, cx_ff, {FRAC_BITS{1'b0}}};
   assign cy_w  = {{(52-FRAC_BITS){1'b0}}, cy_ff, {FRAC_BITS{1'b0}}};
   assign rd_addr = vi_ff;

   // Multiplier operand selection by rotation step or projection pass.
   always_comb begin
      mul_a = a_v;
      mul_b = c_s;
      if (state_ff == S_ROT) begin
         case (step_ff)
            3'd0:    begin mul_a = a_v; mul_b = c_s;  end
            3'd1:    begin mul_a = z_v; mul_b = k1_s; end
            3'd2:    begin mul_a = z_v; mul_b = c_s;  end
            default: begin mul_a = a_v; mul_b = k2_s; end
         endcase
      end else begin
         mul_a = pass_ff ? ys_ff : xs_ff;
         mul_b = f_s;
      end
   end

   // Rounding of the rotation sums, divider step and quotient sign.
   assign rnd_a  = (acca_ff + AC'(64'sd536870912)) >>> 30;
   assign rnd_b  = (accb_ff + AC'(64'sd536870912)) >>> 30;
   assign rem_sh = {rem_ff[DW-2:0], num_ff[MW-1]};
   assign diff   = rem_sh - den_ff;
   assign q_s    = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
   assign scr    = pass_ff ? (cy_w - 64'(q_s)) : (cx_w + 64'(q_s));

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; vi_in = vi_ff; step_in = step_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      offx_in = offx_ff; offy_in = offy_ff; offz_in = offz_ff;
      acca_in = acca_ff; accb_in = accb_ff; prod_in = prod_ff;
      xs_in = xs_ff; ys_in = ys_ff; den_in = den_ff; pass_in = pass_ff;
      num_in = num_ff; rem_in = rem_ff; neg_in = neg_ff; cnt_in = cnt_ff; sx_in = sx_ff;
      ov_in = 1'b0; ol_in = ol_ff; ob_in = ob_ff; oi_in = oi_ff;
      osx_in = osx_ff; osy_in = osy_ff;
      vld_in = vld_ff;
      mem_we = 1'b0; mem_waddr = vi_ff; mem_wdata = {vx_ff, vy_ff, vz_ff};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               vi_in = '0;
               state_in = S_READ;
               if (req_cmd == vrp_pkg::CMD_LOAD && idx_w < 32'(NUM_VERTICES)) begin
                  mem_we = 1'b1;
                  mem_waddr = idx_w[AW-1:0];
                  mem_wdata = {req_in_x, req_in_y, req_in_z};
                  vld_in[idx_w[AW-1:0]] = 1'b1;
               end
               if (req_cmd == vrp_pkg::CMD_TRANS) begin
                  offx_in = vrp_pkg::sat_coord(64'(offx_ff) + 64'(req_in_x));
                  offy_in = vrp_pkg::sat_coord(64'(offy_ff) + 64'(req_in_y));
                  offz_in = vrp_pkg::sat_coord(64'(offz_ff) + 64'(req_in_z));
               end
            end
         end
         S_READ: state_in = S_LATCH;
         S_LATCH: begin
            vx_in = rd_vld_ff ? rd_data_ff[3*CW-1:2*CW] : '0;
            vy_in = rd_vld_ff ? rd_data_ff[2*CW-1:CW]   : '0;
            vz_in = rd_vld_ff ? rd_data_ff[CW-1:0]      : '0;
            step_in = '0;
            state_in = is_rot ? S_ROT : S_PROJ;
         end
         S_ROT: begin
            // One product per cycle; the previous product is accumulated.
            prod_in = mul_a * mul_b;
            case (step_ff)
               3'd1:    acca_in = AC'(prod_ff);
               3'd2:    acca_in = acca_ff + AC'(prod_ff);
               3'd3:    accb_in = AC'(prod_ff);
               3'd4:    accb_in = accb_ff + AC'(prod_ff);
               default: ;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (about_y) begin
               vx_in = vrp_pkg::sat_coord(64'(rnd_a));
            end else begin
               vy_in = vrp_pkg::sat_coord(64'(rnd_a));
            end
            vz_in = vrp_pkg::sat_coord(64'(rnd_b));
            mem_we = 1'b1;
            mem_waddr = vi_ff;
            mem_wdata = {vx_in, vy_in, vz_in};
            vld_in[vi_ff] = 1'b1;
            state_in = S_PROJ;
         end
         S_PROJ: begin
            xs_in = (CW+1)'(offx_ff) + (CW+1)'(vx_ff);
            ys_in = (CW+1)'(offy_ff) + (CW+1)'(vy_ff);
            den_in = DW'(offz_ff) + DW'(vz_ff) + DW'(f_s);
            state_in = S_CHK;
         end
         S_CHK: begin
            pass_in = 1'b0;
            if (den_ff <= 0) begin
               ov_in = 1'b1; ob_in = 1'b1; osx_in = '0; osy_in = '0;
               oi_in = vi_w[1:0]; ol_in = vlast;
               vi_in = vi_ff + AW'(1);
               state_in = vlast ? S_IDLE : S_READ;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = mul_a * mul_b;
            state_in = S_DSET;
         end
         S_DSET: begin
            neg_in = prod_ff[MW-1];
            num_in = prod_ff[MW-1] ? MW'(-prod_ff) : MW'(prod_ff);
            rem_in = '0;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (!diff[DW-1]) begin
               rem_in = diff;
               num_in = {num_ff[MW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[MW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + vrp_pkg::CNT_W'(1);
            if (cnt_ff == vrp_pkg::CNT_W'(MW-1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!pass_ff) begin
               sx_in = vrp_pkg::sat_coord(scr);
               pass_in = 1'b1;
               state_in = S_MUL;
            end else begin
               ov_in = 1'b1; ob_in = 1'b0; osx_in = sx_ff;
               osy_in = vrp_pkg::sat_coord(scr);
               oi_in = vi_w[1:0]; ol_in = vlast;
               vi_in = vi_ff + AW'(1);
               state_in = vlast ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= '0;
         offx_ff  <= '0;
         offy_ff  <= '0;
         offz_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         offx_ff  <= offx_in;
         offy_ff  <= offy_in;
         offz_ff  <= offz_in;
         ov_ff    <= ov_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; vi_ff <= vi_in; step_ff <= step_in;
      vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
      acca_ff <= acca_in; accb_ff <= accb_in; prod_ff <= prod_in;
      xs_ff <= xs_in; ys_ff <= ys_in; den_ff <= den_in; pass_ff <= pass_in;
      num_ff <= num_in; rem_ff <= rem_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      sx_ff <= sx_in; ol_ff <= ol_in; ob_ff <= ob_in; oi_ff <= oi_in;
      osx_ff <= osx_in; osy_ff <= osy_in;
   end

   // Vertex memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   assign rsp_valid     = ov_ff;
   assign rsp_out_index = oi_ff;
   assign rsp_screen_x  = osx_ff;
   assign rsp_screen_y  = osy_ff;
   assign rsp_behind    = ob_ff;
   assign rsp_last      = ol_ff;

   `VRP_ASSERT_SAME(a_mid_busy, clock, reset, rsp_valid && !rsp_last, busy, "result before last while idle")
   `VRP_ASSERT_NEXT(a_gap, clock, reset, rsp_valid, !rsp_valid, "back-to-back result beats")
   `VRP_ASSERT_NEXT(a_start, clock, reset, accept, busy, "command not taken")
   `VRP_ASSERT_SAME(a_behind, clock, reset, rsp_valid && rsp_behind, rsp_screen_x == 24'sd0 && rsp_screen_y == 24'sd0, "behind result not zero")
endmodule

[dv/tb_top.sv]
// Self-checking testbench for vertex_rotate_and_project_top: a projection predictor
// in a small scoreboard class, command and register-write tasks, and a result monitor.
// Depends on vrp_pkg and the RTL of the block.
module tb_top;
   localparam int NVERT      = 4;
   localparam int CYCLE_CAP  = 3000000;
   localparam int DRAIN_WAIT = 700;

   typedef struct {
      logic [1:0]         index;
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      logic               behind;
      logic               last;
   } proj_type;

   // Keeps its own copy of the vertices, offset and registers and predicts
   // the projection beats that each accepted command causes.
   class proj_scoreboard;
      longint vx[NVERT];
      longint vy[NVERT];
      longint vz[NVERT];
      longint ox, oy, oz;
      longint focal, cx, cy, rcos, rsin;
      proj_type pending[$];
      int     errors;

      function new();
         for (int i = 0; i < NVERT; i++) begin
            vx[i] = 0;
            vy[i] = 0;
            vz[i] = 0;
         end
         ox = 0;
         oy = 0;
         oz = 0;
         focal = vrp_pkg::FOCAL_RST;
         cx = vrp_pkg::CX_RST;
         cy = vrp_pkg::CY_RST;
         rcos = vrp_pkg::COS_RST;
         rsin = vrp_pkg::SIN_RST;
         errors = 0;
      endfunction

      function longint clamp(longint v);
         if (v > 64'sd8388607) return 64'sd8388607;
         if (v < -64'sd8388608) return -64'sd8388608;
         return v;
      endfunction

      // Round a Q30 product sum to the nearest, ties upward, then clamp.
      function longint rot_round(longint acc);
         return clamp((acc + (64'sd1 <<< 29)) >>> 30);
      endfunction

      function void set_reg(logic [2:0] idx, longint val);
         case (idx)
            vrp_pkg::REG_FOCAL: focal = val & 64'h7FFF;
            vrp_pkg::REG_CX:    cx = val & 64'hFFF;
            vrp_pkg::REG_CY:    cy = val & 64'hFFF;
            vrp_pkg::REG_COS:   rcos = val & 64'h7FFFFFFF;
            vrp_pkg::REG_SIN:   rsin = val & 64'h7FFFFFFF;
            default: ;
         endcase
      endfunction

      function void rotate(bit about_y, bit neg);
         longint c, s, a, z;
         c = rcos;
         s = neg ? -rsin : rsin;
         for (int i = 0; i < NVERT; i++) begin
            z = vz[i];
            if (about_y) begin
               a = vx[i];
               vx[i] = rot_round(a * c + z * s);
               vz[i] = rot_round(-a * s + z * c);
            end else begin
               a = vy[i];
               vy[i] = rot_round(a * c - z * s);
               vz[i] = rot_round(a * s + z * c);
            end
         end
      endfunction

      function void note_command(logic [2:0] cmd, logic [1:0] idx, logic signed [23:0] x,
                                 logic signed [23:0] y, logic signed [23:0] z);
         longint f, px, py, den;
         proj_type p;
         case (cmd)
            vrp_pkg::CMD_LOAD: begin
               vx[idx] = x;
               vy[idx] = y;
               vz[idx] = z;
            end
            vrp_pkg::CMD_TRANS: begin
               ox = clamp(ox + longint'(x));
               oy = clamp(oy + longint'(y));
               oz = clamp(oz + longint'(z));
            end
            vrp_pkg::CMD_ROT_YP: rotate(1, 0);
            vrp_pkg::CMD_ROT_YN: rotate(1, 1);
            vrp_pkg::CMD_ROT_XP: rotate(0, 0);
            vrp_pkg::CMD_ROT_XN: rotate(0, 1);
            default: ;
         endcase
         f = focal <<< 8;
         for (int i = 0; i < NVERT; i++) begin
            px = ox + vx[i];
            py = oy + vy[i];
            den = oz + vz[i] + f;
            p.index = i[1:0];
            p.last = (i == NVERT - 1);
            if (den > 0) begin
               p.sx = 24'(clamp((cx <<< 8) + (px * f) / den));
               p.sy = 24'(clamp((cy <<< 8) - (py * f) / den));
               p.behind = 1'b0;
            end else begin
               p.sx = '0;
               p.sy = '0;
               p.behind = 1'b1;
            end
            pending.push_back(p);
         end
      endfunction

      function void check_result(proj_type got);
         proj_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: idx %0d x %0d y %0d", got.index, got.sx,
                        got.sy);
            return;
         end
         want = pending.pop_front();
         if (got.index !== want.index || got.sx !== want.sx || got.sy !== want.sy ||
             got.behind !== want.behind || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp idx %0d x %0d y %0d b %0b l %0b, ",
                         "got idx %0d x %0d y %0d b %0b l %0b"},
                        want.index, want.sx, want.sy, want.behind, want.last,
                        got.index, got.sx, got.sy, got.behind, got.last);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_cmd;
   logic [1:0]         req_vertex_index;
   logic signed [23:0] req_in_x;
   logic signed [23:0] req_in_y;
   logic signed [23:0] req_in_z;
   logic               rsp_valid;
   logic [1:0]         rsp_out_index;
   logic signed [23:0] rsp_screen_x;
   logic signed [23:0] rsp_screen_y;
   logic               rsp_behind;
   logic               rsp_last;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [4:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   proj_scoreboard sb;
   int  cycles;
   bit  no_gaps;

   vertex_rotate_and_project_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_vertex_index(req_vertex_index),
      .req_in_x(req_in_x), .req_in_y(req_in_y), .req_in_z(req_in_z),
      .rsp_valid(rsp_valid), .rsp_out_index(rsp_out_index),
      .rsp_screen_x(rsp_screen_x), .rsp_screen_y(rsp_screen_y),
      .rsp_behind(rsp_behind), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle cap: a hung block ends the run here.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Note accepted commands and check every result beat.
   always @(posedge clock) begin
      proj_type got;
      if (!reset && start && !busy)
         sb.note_command(req_cmd, req_vertex_index, req_in_x, req_in_y, req_in_z);
      if (!reset && rsp_valid) begin
         got.index = rsp_out_index;
         got.sx = rsp_screen_x;
         got.sy = rsp_screen_y;
         got.behind = rsp_behind;
         got.last = rsp_last;
         sb.check_result(got);
      end
   end

   // One register write: setup cycle, then access cycle.
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      sb.set_reg(idx, val);
   endtask

   // Present one command beat and hold it until the block takes it.
   task automatic send_cmd(logic [2:0] cmd, logic [1:0] idx, logic signed [23:0] x,
                           logic signed [23:0] y, logic signed [23:0] z);
      bit taken;
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 15) @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_vertex_index = idx;
      req_in_x = x;
      req_in_y = y;
      req_in_z = z;
      do begin
         @(posedge clock);
         taken = !busy;
         @(negedge clock);
      end while (!taken);
      start = 1'b0;
   endtask

   // Wait until every predicted beat has arrived and the block is idle.
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [23:0] pick_coord();
      case ($urandom_range(9))
         0, 1: return 24'($urandom);
         2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
         default: return 24'($signed($urandom_range(131071)) - 65536);
      endcase
   endfunction

   // A random command: mostly loads and rotations, a few unused codes.
   task automatic random_cmd();
      logic [2:0] cmd;
      int r;
      r = $urandom_range(99);
      if (r < 35) cmd = vrp_pkg::CMD_LOAD;
      else if (r < 50) cmd = vrp_pkg::CMD_TRANS;
      else if (r < 90) cmd = 3'($urandom_range(vrp_pkg::CMD_ROT_XN, vrp_pkg::CMD_ROT_YP));
      else cmd = 3'($urandom_range(7, 6));
      if (cmd == vrp_pkg::CMD_TRANS && $urandom_range(3) != 0)
         send_cmd(cmd, 2'($urandom), 24'($signed($urandom_range(8191)) - 4096),
                  24'($signed($urandom_range(8191)) - 4096),
                  24'($signed($urandom_range(8191)) - 4096));
      else
         send_cmd(cmd, 2'($urandom), pick_coord(), pick_coord(), pick_coord());
   endtask

   initial begin
      sb = new();
      no_gaps = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = vrp_pkg::CMD_LOAD;
      req_vertex_index = '0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: loads at the coordinate extremes, every command, unused codes.
      send_cmd(vrp_pkg::CMD_LOAD, 2'd0, 24'sd25600, 24'sd12800, 24'sd0);
      send_cmd(vrp_pkg::CMD_LOAD, 2'd1, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
      send_cmd(vrp_pkg::CMD_LOAD, 2'd2, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
      send_cmd(vrp_pkg::CMD_LOAD, 2'd3, -24'sd2560, 24'sd2560, -24'sd256000);
      send_cmd(vrp_pkg::CMD_ROT_YP, 2'd0, '0, '0, '0);
      send_cmd(vrp_pkg::CMD_ROT_YN, 2'd0, '0, '0, '0);
      send_cmd(vrp_pkg::CMD_ROT_XP, 2'd0, '0, '0, '0);
      send_cmd(vrp_pkg::CMD_ROT_XN, 2'd0, '0, '0, '0);
      send_cmd(3'd6, 2'd3, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      send_cmd(3'd7, 2'd1, '0, '0, '0);
      send_cmd(vrp_pkg::CMD_TRANS, 2'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      send_cmd(vrp_pkg::CMD_TRANS, 2'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      send_cmd(vrp_pkg::CMD_TRANS, 2'd0, 24'sh800000, 24'sh800000, 24'sh800000);
      send_cmd(vrp_pkg::CMD_TRANS, 2'd0, 24'sh800000, 24'sh800000, 24'sh800000);
      send_cmd(vrp_pkg::CMD_TRANS, 2'd0, 24'sh800000, 24'sh800000, 24'sh800000);
      // Offset now at its minimum; the load below puts vertex 0 at the largest z.
      send_cmd(vrp_pkg::CMD_LOAD, 2'd0, 24'sd0, 24'sd0, 24'sh7FFFFF);
      drain();

      // Register extremes: zero focal length, far corners, oversized rotation.
      write_reg(vrp_pkg::REG_FOCAL, 32'd0);
      write_reg(vrp_pkg::REG_CX, 32'd4095);
      write_reg(vrp_pkg::REG_CY, 32'd0);
      write_reg(vrp_pkg::REG_COS, 32'h7FFFFFFF);
      write_reg(vrp_pkg::REG_SIN, 32'h7FFFFFFF);
      send_cmd(vrp_pkg::CMD_TRANS, 2'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      send_cmd(vrp_pkg::CMD_ROT_YP, 2'd0, '0, '0, '0);
      send_cmd(vrp_pkg::CMD_ROT_XN, 2'd0, '0, '0, '0);
      drain();
      write_reg(vrp_pkg::REG_FOCAL, 32'd32767);
      write_reg(vrp_pkg::REG_CX, 32'd0);
      write_reg(vrp_pkg::REG_CY, 32'd4095);
      write_reg(vrp_pkg::REG_COS, 32'd0);
      write_reg(vrp_pkg::REG_SIN, 32'd1073741824);
      send_cmd(vrp_pkg::CMD_LOAD, 2'd2, 24'sd5000, -24'sd7000, 24'sd9000);
      send_cmd(vrp_pkg::CMD_ROT_YN, 2'd0, '0, '0, '0);
      send_cmd(vrp_pkg::CMD_ROT_XP, 2'd0, '0, '0, '0);
      drain();

      // Random phases, each with its own register setting.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_reg(vrp_pkg::REG_FOCAL, 32'(vrp_pkg::FOCAL_RST));
               write_reg(vrp_pkg::REG_CX, 32'(vrp_pkg::CX_RST));
               write_reg(vrp_pkg::REG_CY, 32'(vrp_pkg::CY_RST));
               write_reg(vrp_pkg::REG_COS, 32'(vrp_pkg::COS_RST));
               write_reg(vrp_pkg::REG_SIN, 32'(vrp_pkg::SIN_RST));
            end
            1: begin
               write_reg(vrp_pkg::REG_FOCAL, 32'd1);
               write_reg(vrp_pkg::REG_COS, 32'd759250125);
               write_reg(vrp_pkg::REG_SIN, 32'd759250125);
            end
            2: begin
               write_reg(vrp_pkg::REG_FOCAL, 32'd32767);
               write_reg(vrp_pkg::REG_CX, 32'd0);
               write_reg(vrp_pkg::REG_CY, 32'd4095);
            end
            default: begin
               write_reg(vrp_pkg::REG_FOCAL, $urandom_range(32767));
               write_reg(vrp_pkg::REG_CX, $urandom_range(4095));
               write_reg(vrp_pkg::REG_CY, $urandom_range(4095));
               write_reg(vrp_pkg::REG_COS, $urandom_range(1073741824, 1000000000));
               write_reg(vrp_pkg::REG_SIN, $urandom_range(400000000));
            end
         endcase
         // Pull the offset back near the origin so projections stay interesting.
         send_cmd(vrp_pkg::CMD_TRANS, 2'd0, 24'(-sb.ox), 24'(-sb.oy), 24'(-sb.oz));
         no_gaps = (ph == 2);
         for (int n = 0; n < 76; n++) begin
            random_cmd();
            if (n == 40) drain();
         end
         no_gaps = 1'b0;
         drain();
      end

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+src
src/vrp_pkg.sv
src/vertex_rotate_and_project_top.sv
dv/tb_top.sv
